FILE: rtl/core/cbcp_pkg.sv
// Package for the circle/box collision push-out block.
// Holds coordinate widths, the register map, the box and query word types
// and the coordinate saturation function. No dependencies.
`default_nettype none

package cbcp_pkg;

  localparam int MAX_BOXES_DEF = 64;

  localparam int COORD_BITS = 24;            // signed Q15.8 coordinate
  localparam int DIM_BITS   = COORD_BITS - 1; // unsigned width and height
  localparam int RAD_BITS   = 16;            // unsigned Q8.8 radius
  localparam int EDGE_BITS  = COORD_BITS + 1; // edge sums and square bounds
  localparam int WIDE_BITS  = COORD_BITS + 2; // doubled midlines and pushes
  localparam int INDEX_BITS = 6;
  localparam int COUNT_BITS = 7;

  localparam int S_DATA_BITS = 168;
  localparam int M_DATA_BITS = 2 * COORD_BITS;

  // Input kinds carried in s_tuser.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_BOX_COUNT = 1'b0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic        [DIM_BITS-1:0]   width;
    logic        [DIM_BITS-1:0]   height;
  } box_t;

  typedef struct packed {
    logic                         we;
    box_t                         box;
  } load_t;

  // Query word handed from cell to cell.
  typedef struct packed {
    logic                         valid;
    logic                         hit;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [RAD_BITS-1:0]   rad;
    logic signed [EDGE_BITS-1:0]  sq_l;
    logic signed [EDGE_BITS-1:0]  sq_r;
    logic signed [EDGE_BITS-1:0]  sq_t;
    logic signed [EDGE_BITS-1:0]  sq_b;
  } token_t;

  // Saturate a wide sum to the signed coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic [WIDE_BITS-COORD_BITS:0] upper;
    logic signed [COORD_BITS-1:0]  res;
    upper = v[WIDE_BITS-1:COORD_BITS-1];
    if ((upper == '0) || (upper == '1)) begin
      res = v[COORD_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbcp_cell.sv
// One cell of the box chain: holds one box and applies its push-out to the
// query word passing through. Depends on cbcp_pkg.
`default_nettype none

module cbcp_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            enable,
  input  wire cbcp_pkg::load_t load,
  input  wire cbcp_pkg::token_t tok_in,
  output cbcp_pkg::token_t     tok_out
);

  localparam int CB = cbcp_pkg::COORD_BITS;
  localparam int EB = cbcp_pkg::EDGE_BITS;
  localparam int WB = cbcp_pkg::WIDE_BITS;
  localparam int DB = cbcp_pkg::DIM_BITS;
  localparam int RB = cbcp_pkg::RAD_BITS;

  // Box edges, with right/bottom edges and doubled midlines prepared at load.
  logic signed [CB-1:0] bl;
  logic signed [CB-1:0] bt;
  logic signed [EB-1:0] br;
  logic signed [EB-1:0] bb;
  logic signed [WB-1:0] mx2;
  logic signed [WB-1:0] my2;

  always_ff @(posedge clk) begin
    if (load.we) begin
      bl  <= load.box.left;
      bt  <= load.box.top;
      br  <= $signed({load.box.left[CB-1], load.box.left})
             + $signed({{(EB-DB){1'b0}}, load.box.width});
      bb  <= $signed({load.box.top[CB-1], load.box.top})
             + $signed({{(EB-DB){1'b0}}, load.box.height});
      mx2 <= $signed({load.box.left[CB-1], load.box.left, 1'b0})
             + $signed({{(WB-DB){1'b0}}, load.box.width});
      my2 <= $signed({load.box.top[CB-1], load.box.top, 1'b0})
             + $signed({{(WB-DB){1'b0}}, load.box.height});
    end
  end

  logic signed [EB-1:0] x_e;
  logic signed [EB-1:0] y_e;
  logic signed [EB-1:0] bl_e;
  logic signed [EB-1:0] bt_e;
  logic signed [WB-1:0] rad_w;
  logic                 miss;
  logic                 in_x;
  logic                 in_y;
  logic                 go_up;
  logic                 go_left;
  logic signed [WB-1:0] push_y;
  logic signed [WB-1:0] push_x;
  cbcp_pkg::token_t     tok_next;

  always_comb begin
    x_e   = $signed({tok_in.x[CB-1], tok_in.x});
    y_e   = $signed({tok_in.y[CB-1], tok_in.y});
    bl_e  = $signed({bl[CB-1], bl});
    bt_e  = $signed({bt[CB-1], bt});
    rad_w = $signed({{(WB-RB){1'b0}}, tok_in.rad});

    miss = (bl_e >= tok_in.sq_r) || (bt_e >= tok_in.sq_b) ||
           (br <= tok_in.sq_l) || (bb <= tok_in.sq_t);
    in_x = (x_e >= bl_e) && (x_e < br);
    in_y = (y_e >= bt_e) && (y_e < bb);

    go_up   = $signed({y_e, 1'b0}) < my2;
    go_left = $signed({x_e, 1'b0}) < mx2;
    push_y  = go_up ? ($signed({bt_e[EB-1], bt_e}) - rad_w)
                    : ($signed({bb[EB-1], bb}) + rad_w);
    push_x  = go_left ? ($signed({bl_e[EB-1], bl_e}) - rad_w)
                      : ($signed({br[EB-1], br}) + rad_w);

    tok_next = tok_in;
    if (tok_in.valid && enable && !miss) begin
      if (in_x) begin
        tok_next.y   = cbcp_pkg::sat_coord(push_y);
        tok_next.hit = 1'b1;
      end else if (in_y) begin
        tok_next.x   = cbcp_pkg::sat_coord(push_x);
        tok_next.hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/circle_box_collision_pushout.sv
// A resolve word is accepted into a head register, then passes through the box
// cells in order, each registered, and its result is registered at the output.
// A new resolve is accepted only once the previous word has left the last cell,
// which takes longer while m_tready is low.
// A load is not accepted while a resolve is in the chain.
// Reset clears the control state and box_count; the box table is not cleared
// and a slot reads as garbage until loaded.
// Top level of the circle/box push-out block; instantiates cbcp_cell and
// uses cbcp_pkg.
`default_nettype none

module circle_box_collision_pushout #(
  parameter int MAX_BOXES = cbcp_pkg::MAX_BOXES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata, low bit up: box_index, box_left, box_top, box_width, box_height,
  // pos_x, pos_y, body_radius, zero fill
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [cbcp_pkg::S_DATA_BITS-1:0] s_tdata,
  input  wire logic [0:0]                       s_tuser,  // command
  // m_tdata, low bit up: out_x, out_y
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [cbcp_pkg::M_DATA_BITS-1:0]      m_tdata,
  output logic [0:0]                            m_tuser,  // hit
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [2:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int CB = cbcp_pkg::COORD_BITS;
  localparam int EB = cbcp_pkg::EDGE_BITS;
  localparam int RB = cbcp_pkg::RAD_BITS;
  localparam int NB = cbcp_pkg::COUNT_BITS;

  // Configuration register.
  logic [NB-1:0] box_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cbcp_pkg::REG_BOX_COUNT) ? 32'(box_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == cbcp_pkg::REG_BOX_COUNT) begin
      box_count <= pwdata[NB-1:0];
    end
  end

  // Input field unpacking.
  logic [cbcp_pkg::INDEX_BITS-1:0] box_index;
  cbcp_pkg::box_t                   in_box;
  logic signed [CB-1:0]             pos_x;
  logic signed [CB-1:0]             pos_y;
  logic [RB-1:0]                    body_radius;

  assign box_index     = s_tdata[5:0];
  assign in_box.left   = s_tdata[29:6];
  assign in_box.top    = s_tdata[53:30];
  assign in_box.width  = s_tdata[76:54];
  assign in_box.height = s_tdata[99:77];
  assign pos_x         = s_tdata[123:100];
  assign pos_y         = s_tdata[147:124];
  assign body_radius   = s_tdata[163:148];

  logic s_accept;
  logic load_accept;
  logic query_accept;
  logic busy;
  logic advance;

  assign s_tready     = !busy && !rst;
  assign s_accept     = s_tvalid && s_tready;
  assign load_accept  = s_accept && (s_tuser[0] == cbcp_pkg::CMD_LOAD);
  assign query_accept = s_accept && (s_tuser[0] == cbcp_pkg::CMD_RESOLVE);

  cbcp_pkg::token_t tok [MAX_BOXES+1];
  logic [MAX_BOXES-1:0] chain_valid;

  // The chain only stops when the finished word cannot leave.
  assign advance = !(tok[MAX_BOXES].valid && m_tvalid && !m_tready);

  // Head register: builds the body's square from the original position.
  logic signed [EB-1:0] x_e;
  logic signed [EB-1:0] y_e;
  logic signed [EB-1:0] rad_e;

  assign x_e   = $signed({pos_x[CB-1], pos_x});
  assign y_e   = $signed({pos_y[CB-1], pos_y});
  assign rad_e = $signed({{(EB-RB){1'b0}}, body_radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
      busy         <= 1'b0;
    end else begin
      if (query_accept) begin
        tok[0].valid <= 1'b1;
      end else if (advance) begin
        tok[0].valid <= 1'b0;
      end
      if (query_accept) begin
        busy <= 1'b1;
      end else if (tok[MAX_BOXES].valid && advance) begin
        busy <= 1'b0;
      end
    end
    if (query_accept) begin
      tok[0].hit  <= 1'b0;
      tok[0].x    <= pos_x;
      tok[0].y    <= pos_y;
      tok[0].rad  <= body_radius;
      tok[0].sq_l <= x_e - rad_e;
      tok[0].sq_r <= x_e + rad_e;
      tok[0].sq_t <= y_e - rad_e;
      tok[0].sq_b <= y_e + rad_e;
    end
  end

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    cbcp_pkg::load_t cell_load;
    logic            cell_en;

    assign cell_load.we  = load_accept && (32'(box_index) == 32'(i));
    assign cell_load.box = in_box;
    // A count above the chain length simply enables every cell.
    assign cell_en       = 32'(box_count) > 32'(i);
    assign chain_valid[i] = tok[i+1].valid;

    cbcp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .enable  (cell_en),
      .load    (cell_load),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tok[MAX_BOXES].valid && advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[MAX_BOXES].valid && advance) begin
      m_tdata <= {tok[MAX_BOXES].y, tok[MAX_BOXES].x};
      m_tuser <= tok[MAX_BOXES].hit;
    end
  end

`ifndef SYNTHESIS
  // At most one query word lives in the head register and the chain.
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    $countones({tok[0].valid, chain_valid}) <= 1)
    else $error("more than one query word in the chain");

  // The busy flag tracks exactly the presence of a word in flight.
  a_busy_tracks: assert property (@(posedge clk) disable iff (rst)
    busy == (tok[0].valid || (|chain_valid)))
    else $error("busy flag disagrees with chain contents");

  // An accepted resolve lands in the head register.
  a_head_load: assert property (@(posedge clk) disable iff (rst)
    query_accept |=> tok[0].valid)
    else $error("accepted resolve missing from head register");

  // A new result only appears when the last cell held a word.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(tok[MAX_BOXES].valid))
    else $error("result raised without a finished word");
`endif

endmodule

`default_nettype wire
